/* hw/rtl/oile_pkg.sv */
// Shared types, codes and field layout of the ordered item list engine.
package oile_pkg;

   // Default sizing of the list.
   localparam int unsigned MAX_ITEMS_DEF = 16;
   localparam int unsigned KEY_WIDTH_DEF = 32;

   // Stream widths, padded to whole bytes.
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 56;

   // Request field layout.
   localparam int unsigned REQ_CMD_LSB = 0;
   localparam int unsigned REQ_ID_LSB  = 2;
   localparam int unsigned REQ_KEY_LSB = 6;

   // Response field layout.
   localparam int unsigned RSP_STATUS_LSB     = 0;
   localparam int unsigned RSP_COUNT_LSB      = 2;
   localparam int unsigned RSP_HEAD_VALID_BIT = 7;
   localparam int unsigned RSP_HEAD_ITEM_LSB  = 8;
   localparam int unsigned RSP_HEAD_KEY_LSB   = 12;
   localparam int unsigned RSP_CUR_END_BIT    = 44;
   localparam int unsigned RSP_CUR_ITEM_LSB   = 45;

   typedef enum logic [1:0] {
      CMD_SORTED = 2'd0,
      CMD_CURSOR = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_LISTED   = 2'd1;
   localparam logic [1:0] STAT_UNLISTED = 2'd2;
   localparam logic [1:0] STAT_RSVD     = 2'd3;

endpackage

/* hw/rtl/oile_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module oile_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/ordered_item_list_engine_unit.sv */
// Top level of the ordered item list engine: sorted doubly linked list with a cursor.
// A sorted insert walks the next-link and key memories, one compare a cycle, to find
// its place. The next request is taken the cycle after the response is loaded.
// Reset is synchronous, active high: list empty, cursor on the end sentinel, member
// flags cleared; link and key memories keep their contents and are guarded by the flags.
module ordered_item_list_engine_unit #(
   parameter int unsigned MAX_ITEMS = oile_pkg::MAX_ITEMS_DEF,
   parameter int unsigned KEY_WIDTH = oile_pkg::KEY_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cmd[1:0], item_id[5:2], item_key[37:6], zero pad[39:38]
   input  logic [oile_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], item_count[6:2], head_valid[7], head_item[11:8], head_key[43:12],
   // cursor_at_end[44], cursor_item[48:45], zero pad[55:49]
   output logic [oile_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import oile_pkg::*;

   // Item index width, and position width that also holds the end sentinel.
   localparam int unsigned IW = $clog2(MAX_ITEMS);
   localparam int unsigned PW = $clog2(MAX_ITEMS + 1);
   localparam logic [PW-1:0] SENT = PW'(MAX_ITEMS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CUR_N,
      S_WALK,
      S_LINK,
      S_LINK2,
      S_REMOVE,
      S_HEAD,
      S_DONE
   } state_type;

   // Sequencer and list registers.
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [IW-1:0]        id_ff, id_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [PW-1:0]        p_ff, p_in;      // position the item goes after
   logic [PW-1:0]        n_ff, n_in;      // successor of p
   logic [1:0]           status_ff, status_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [PW-1:0]        cursor_ff, cursor_in;
   logic [PW-1:0]        count_ff, count_in;
   logic [MAX_ITEMS-1:0] member_ff, member_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                 nx_we, pv_we, ky_we;
   logic [IW-1:0]        nx_waddr, pv_waddr, ky_waddr;
   logic [PW-1:0]        nx_wdata, pv_wdata;
   logic [KEY_WIDTH-1:0] ky_wdata;
   logic [IW-1:0]        rd_addr;          // shared by next-link and key memories
   logic [PW-1:0]        nx_rdata, pv_rdata;
   logic [KEY_WIDTH-1:0] ky_rdata;

   // Request fields.
   cmd_type              req_cmd;
   logic [3:0]           req_id;
   logic [31:0]          req_key;
   logic [IW-1:0]        req_idx;
   logic                 req_id_ok;
   logic                 req_listed;
   logic                 req_accept;

   // Response fields.
   logic                 head_valid;
   logic [3:0]           head_item;
   logic [31:0]          head_key;
   logic                 cur_at_end;
   logic [3:0]           cur_item;
   logic [PW-1:0]        id_pos;

   assign req_cmd    = cmd_type'(req_tdata[REQ_CMD_LSB +: 2]);
   assign req_id     = req_tdata[REQ_ID_LSB +: 4];
   assign req_key    = req_tdata[REQ_KEY_LSB +: 32];
   assign req_idx    = IW'(req_id);
   assign req_id_ok  = 32'(req_id) < MAX_ITEMS;
   assign req_listed = req_id_ok && member_ff[req_idx];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign id_pos     = PW'(id_ff);

   // The head key is read from the key memory at head_ff during S_HEAD and held in S_DONE.
   assign head_valid = (head_ff != SENT);
   assign head_item  = head_valid ? 4'(head_ff) : 4'd0;
   assign head_key   = head_valid ? 32'(ky_rdata) : 32'd0;
   assign cur_at_end = (cursor_ff == SENT);
   assign cur_item   = cur_at_end ? 4'd0 : 4'(cursor_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      key_in       = key_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      member_in    = member_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      nx_we    = 1'b0;
      nx_waddr = id_ff;
      nx_wdata = n_ff;
      pv_we    = 1'b0;
      pv_waddr = id_ff;
      pv_wdata = p_ff;
      ky_we    = 1'b0;
      ky_waddr = req_idx;
      ky_wdata = KEY_WIDTH'(req_key);
      rd_addr  = IW'(head_ff);

      // Drop the response once it is taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_cmd;
               id_in     = req_idx;
               key_in    = KEY_WIDTH'(req_key);
               status_in = STAT_OK;
               state_in  = S_HEAD;
               priority if (req_cmd == CMD_NOP) begin
                  status_in = STAT_OK;
               end else if (!req_id_ok) begin
                  status_in = STAT_UNLISTED;
               end else if (req_cmd == CMD_REMOVE) begin
                  if (!req_listed) begin
                     status_in = STAT_UNLISTED;
                  end else begin
                     // Fetch both links of the item; prev memory reads req_idx always.
                     rd_addr  = req_idx;
                     state_in = S_REMOVE;
                  end
               end else if (req_listed) begin
                  status_in = STAT_LISTED;
               end else begin
                  ky_we = 1'b1;
                  if (req_cmd == CMD_CURSOR) begin
                     p_in = cursor_ff;
                     if (cursor_ff == SENT) begin
                        n_in     = head_ff;
                        state_in = S_LINK;
                     end else begin
                        rd_addr  = IW'(cursor_ff);
                        state_in = S_CUR_N;
                     end
                  end else begin
                     // Sorted insert: start the walk at the sentinel.
                     p_in = SENT;
                     n_in = head_ff;
                     if (head_ff == SENT) begin
                        state_in = S_LINK;
                     end else begin
                        rd_addr  = IW'(head_ff);
                        state_in = S_WALK;
                     end
                  end
               end
            end
         end

         S_CUR_N: begin
            n_in     = nx_rdata;
            state_in = S_LINK;
         end

         S_WALK: begin
            // Stop at the first entry with a larger key; equal keys stay ahead.
            if (ky_rdata > key_ff) begin
               state_in = S_LINK;
            end else begin
               p_in = n_ff;
               n_in = nx_rdata;
               if (nx_rdata == SENT) begin
                  state_in = S_LINK;
               end else begin
                  rd_addr = IW'(nx_rdata);
               end
            end
         end

         S_LINK: begin
            nx_we    = 1'b1;
            nx_waddr = id_ff;
            nx_wdata = n_ff;
            pv_we    = 1'b1;
            pv_waddr = id_ff;
            pv_wdata = p_ff;
            state_in = S_LINK2;
         end

         S_LINK2: begin
            if (n_ff == SENT) begin
               tail_in = id_pos;
            end else begin
               pv_we    = 1'b1;
               pv_waddr = IW'(n_ff);
               pv_wdata = id_pos;
            end
            if (p_ff == SENT) begin
               head_in = id_pos;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = IW'(p_ff);
               nx_wdata = id_pos;
            end
            member_in[id_ff] = 1'b1;
            count_in         = count_ff + PW'(1);
            if (cmd_ff == CMD_CURSOR) begin
               cursor_in = id_pos;
            end
            state_in = S_HEAD;
         end

         S_REMOVE: begin
            // Bridge predecessor and successor around the item.
            if (nx_rdata == SENT) begin
               tail_in = pv_rdata;
            end else begin
               pv_we    = 1'b1;
               pv_waddr = IW'(nx_rdata);
               pv_wdata = pv_rdata;
            end
            if (pv_rdata == SENT) begin
               head_in = nx_rdata;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = IW'(pv_rdata);
               nx_wdata = nx_rdata;
            end
            if (cursor_ff == id_pos) begin
               cursor_in = pv_rdata;
            end
            member_in[id_ff] = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - PW'(1);
            end
            state_in = S_HEAD;
         end

         S_HEAD: begin
            // Read the key at the updated head.
            state_in = S_DONE;
         end

         S_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, cur_item, cur_at_end, head_key, head_item,
                               head_valid, 5'(count_ff), status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= SENT;
         tail_ff      <= SENT;
         cursor_ff    <= SENT;
         count_ff     <= '0;
         member_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         member_ff    <= member_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Successor links.
   oile_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (rd_addr),
      .rd_data (nx_rdata)
   );

   // Predecessor links.
   oile_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (req_idx),
      .rd_data (pv_rdata)
   );

   // Item keys.
   oile_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ITEMS)) u_key_ram (
      .clock   (clock),
      .wr_en   (ky_we),
      .wr_addr (ky_waddr),
      .wr_data (ky_wdata),
      .rd_addr (rd_addr),
      .rd_data (ky_rdata)
   );
endmodule

/* hw/rtl/oile_checker.sv */
// Port-level checks of the ordered item list engine, bound to its top level.
module oile_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [oile_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [oile_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import oile_pkg::*;

   logic [1:0]  status;
   logic [4:0]  count;
   logic        head_valid;
   logic [3:0]  head_item;
   logic [31:0] head_key;
   logic        cur_end;
   logic [3:0]  cur_item;
   logic        req_seen;

   assign status     = rsp_tdata[RSP_STATUS_LSB +: 2];
   assign count      = rsp_tdata[RSP_COUNT_LSB +: 5];
   assign head_valid = rsp_tdata[RSP_HEAD_VALID_BIT];
   assign head_item  = rsp_tdata[RSP_HEAD_ITEM_LSB +: 4];
   assign head_key   = rsp_tdata[RSP_HEAD_KEY_LSB +: 32];
   assign cur_end    = rsp_tdata[RSP_CUR_END_BIT];
   assign cur_item   = rsp_tdata[RSP_CUR_ITEM_LSB +: 4];
   assign req_seen   = req_tvalid && req_tready;

   // A stalled response holds its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status != STAT_RSVD)
      else $error("reserved status code");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> head_valid == (count != 5'd0))
      else $error("head valid disagrees with item count");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !head_valid |-> head_item == 4'd0 && head_key == 32'd0)
      else $error("empty list reports a head");

   // A sentinel cursor reports no item; while such a response is valid, requests must not be accepted back to back.
   a_cursor_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cur_end |-> cur_item == 4'd0 && !(req_seen && $past(req_seen)))
      else $error("cursor on end sentinel reports an item");
endmodule

bind ordered_item_list_engine_unit oile_checker u_oile_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/testbench.sv */
// Self-checking testbench for the ordered item list engine unit.
`timescale 1ns / 100ps

module testbench;
   import oile_pkg::*;

   // Responses may stall for a while, and a sorted insert walks up to fifteen entries,
   // so allow this many cycles with no transfer on either channel before giving up.
   localparam int QUIET_LIMIT = 2000;
   // Extra cycles to watch for stray responses once every expected one has arrived.
   localparam int DRAIN_CYCLES = 12;
   // Position one past the last item id: the end sentinel of the ring.
   localparam logic [4:0] END_POS = 5'd16;

   // One response: what the list looks like after a command.
   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  item_count;
      logic        head_valid;
      logic [3:0]  head_item;
      logic [31:0] head_key;
      logic        cursor_at_end;
      logic [3:0]  cursor_item;
   } list_view_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // cmd[1:0], item_id[5:2], item_key[37:6], zero pad[39:38]
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // status[1:0], item_count[6:2], head_valid[7], head_item[11:8], head_key[43:12],
   // cursor_at_end[44], cursor_item[48:45], zero pad[55:49]
   logic [RSP_TDATA_W-1:0]   rsp_tdata;

   // Shadow copy of the list, updated as each request transfer is accepted.
   logic [4:0]  next_pos [16];
   logic [4:0]  prev_pos [16];
   logic [31:0] item_keys [16];
   logic        on_list [16];
   logic [4:0]  head_pos;
   logic [4:0]  tail_pos;
   logic [4:0]  cursor_pos;
   logic [4:0]  listed_count;

   list_view_type pending_views [$];   // expected responses, oldest first
   bit       idle_on;             // random gaps on both channels when set
   int       fail_count;
   int       checked_count;
   int       flagged_count;
   int       quiet_cycles;
   int       cmd_seen [4];
   int       max_fill;

   ordered_item_list_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Shadow list. The sentinel's successor is the head and its predecessor the tail.
   // ---------------------------------------------------------------------------------
   function automatic logic [4:0] succ_of(logic [4:0] p);
      return (p == END_POS) ? head_pos : next_pos[p[3:0]];
   endfunction

   function automatic void set_succ(logic [4:0] p, logic [4:0] v);
      if (p == END_POS) head_pos = v; else next_pos[p[3:0]] = v;
   endfunction

   function automatic void set_pred(logic [4:0] p, logic [4:0] v);
      if (p == END_POS) tail_pos = v; else prev_pos[p[3:0]] = v;
   endfunction

   function automatic void link_after(logic [4:0] p, logic [3:0] id);
      logic [4:0] n;
      n = succ_of(p);
      next_pos[id] = n;
      prev_pos[id] = p;
      set_pred(n, {1'b0, id});
      set_succ(p, {1'b0, id});
      on_list[id] = 1'b1;
      listed_count++;
   endfunction

   function automatic void clear_list();
      for (int i = 0; i < 16; i++) on_list[i] = 1'b0;
      head_pos     = END_POS;
      tail_pos     = END_POS;
      cursor_pos   = END_POS;
      listed_count = '0;
   endfunction

   // Apply one command to the shadow list and return the response it must produce.
   function automatic list_view_type list_after_command(cmd_type op, logic [3:0] id,
                                                        logic [31:0] key);
      list_view_type v;
      logic [4:0]    p;
      logic [4:0]    n;
      v = '0;
      v.status = STAT_OK;
      case (op)
         CMD_REMOVE: begin
            if (!on_list[id]) begin
               v.status = STAT_UNLISTED;
            end else begin
               p = prev_pos[id];
               n = next_pos[id];
               set_pred(n, p);
               set_succ(p, n);
               // The cursor falls back to the predecessor, possibly the sentinel.
               if (cursor_pos == {1'b0, id}) cursor_pos = p;
               on_list[id] = 1'b0;
               if (listed_count != 0) listed_count--;
            end
         end
         CMD_SORTED, CMD_CURSOR: begin
            if (on_list[id]) begin
               v.status = STAT_LISTED;
            end else begin
               item_keys[id] = key;
               if (op == CMD_CURSOR) begin
                  link_after(cursor_pos, id);
                  cursor_pos = {1'b0, id};
               end else begin
                  // Step past every entry whose key is not greater: ties stay in FIFO order.
                  p = END_POS;
                  n = succ_of(p);
                  while (n != END_POS && item_keys[n[3:0]] <= key) begin
                     p = n;
                     n = succ_of(p);
                  end
                  link_after(p, id);
               end
            end
         end
         default: ;
      endcase
      v.item_count = listed_count;
      if (head_pos != END_POS) begin
         v.head_valid = 1'b1;
         v.head_item  = head_pos[3:0];
         v.head_key   = item_keys[head_pos[3:0]];
      end
      if (cursor_pos == END_POS) v.cursor_at_end = 1'b1;
      else v.cursor_item = cursor_pos[3:0];
      return v;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side: one transfer per call. Valid stays high after acceptance so that
   // back-to-back items keep it asserted; a gap in the next call or the end of the run lowers it.
   // ---------------------------------------------------------------------------------
   task automatic send_item(cmd_type op, logic [3:0] id, logic [31:0] key);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[REQ_CMD_LSB +: 2] = op;
      word[REQ_ID_LSB +: 4]  = id;
      word[REQ_KEY_LSB +: 32] = key;
      while (idle_on && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_views.push_back(list_after_command(op, id, key));
      cmd_seen[op]++;
      if (listed_count > max_fill) max_fill = listed_count;
   endtask

   // Choose an id that is on the list (or off it); fall back to any id if none fits.
   function automatic logic [3:0] pick_id(bit want_listed);
      logic [3:0] choices [$];
      for (int i = 0; i < 16; i++)
         if (on_list[i] == want_listed) choices.push_back(i[3:0]);
      if (choices.size() == 0) return 4'($urandom_range(15));
      return choices[$urandom_range(choices.size() - 1)];
   endfunction

   // Keys: small ones for frequent ties, near-top ones, top-nibble-only ones and full-range ones.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0:       return 32'($urandom_range(7));
         1:       return 32'hFFFF_FFF8 | 32'($urandom_range(7));
         2:       return 32'($urandom_range(15)) << 28;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Walk the special cases by hand: empty list, sentinel cursor, ties, flagged ids.
   task automatic test_directed();
      send_item(CMD_REMOVE, 4'd4,  32'h0);           // remove from an empty list
      send_item(CMD_NOP,    4'd15, 32'hFFFF_FFFF);   // unused code on an empty list
      send_item(CMD_CURSOR, 4'd5,  32'h0);           // cursor on sentinel: link at head
      send_item(CMD_SORTED, 4'd15, 32'hFFFF_FFFF);   // largest key goes to the tail
      send_item(CMD_SORTED, 4'd0,  32'h0);           // tie with the head: after it
      send_item(CMD_SORTED, 4'd3,  32'h8000_0000);
      send_item(CMD_SORTED, 4'd7,  32'h8000_0000);   // tie: keep arrival order
      send_item(CMD_SORTED, 4'd3,  32'h1);           // already listed
      send_item(CMD_CURSOR, 4'd5,  32'h2);           // already listed
      send_item(CMD_CURSOR, 4'd9,  32'h0000_1234);   // after the cursor, out of key order
      send_item(CMD_SORTED, 4'd12, 32'h0);
      send_item(CMD_REMOVE, 4'd9,  32'hDEAD_BEEF);   // cursor item: step back
      send_item(CMD_REMOVE, 4'd5,  32'h0);           // head; the cursor stays on 12
      send_item(CMD_REMOVE, 4'd5,  32'h0);           // no longer listed
      send_item(CMD_CURSOR, 4'd2,  32'hAAAA_5555);   // after the cursor item 12
      send_item(CMD_REMOVE, 4'd15, 32'h0);           // tail
      send_item(CMD_REMOVE, 4'd2,  32'h0);           // under the cursor: step back to 12
      send_item(CMD_NOP,    4'd0,  32'h0);
      send_item(CMD_REMOVE, 4'd0,  32'h0);
      send_item(CMD_REMOVE, 4'd12, 32'h0);
      send_item(CMD_REMOVE, 4'd3,  32'h0);
      send_item(CMD_REMOVE, 4'd7,  32'h0);
   endtask

   // Fill the list to all sixteen ids, poke it while full, then empty it.
   // Ascending keys make each sorted insert walk the whole list.
   task automatic test_fill_and_drain(bit ascending);
      logic [3:0] order [16];
      logic [3:0] t;
      int         j;
      for (int i = 0; i < 16; i++) order[i] = i[3:0];
      for (int i = 15; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < 16; i++)
         send_item(CMD_SORTED, order[i],
                   ascending ? 32'(i >> 1) : 32'hFFFF_FFFF - 32'(i));
      send_item(CMD_SORTED, order[$urandom_range(15)], $urandom);
      send_item(CMD_CURSOR, order[$urandom_range(15)], $urandom);
      send_item(CMD_NOP,    4'($urandom_range(15)),    $urandom);
      for (int i = 15; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < 16; i++) send_item(CMD_REMOVE, order[i], $urandom);
   endtask

   // Mostly legal commands on the right ids; a tenth target the wrong ids to get flagged.
   // Lean toward inserts when the list is short and toward removes when it is long.
   task automatic test_random(int n);
      int         roll;
      int         insert_pct;
      cmd_type    op;
      logic [3:0] id;
      for (int i = 0; i < n; i++) begin
         insert_pct = (listed_count < 4) ? 75 : (listed_count > 12) ? 30 : 55;
         roll = $urandom_range(99);
         if (roll < 3) op = CMD_NOP;
         else if (roll < 3 + insert_pct)
            op = ($urandom_range(2) == 0) ? CMD_CURSOR : CMD_SORTED;
         else op = CMD_REMOVE;
         if (op == CMD_REMOVE) id = pick_id($urandom_range(9) != 0);
         else id = pick_id($urandom_range(9) == 0);
         send_item(op, id, pick_key());
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Response side: random stalls while idling is on, always ready otherwise.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= 20);
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
      end
   endtask

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      list_view_type want;
      list_view_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status        = rsp_tdata[RSP_STATUS_LSB +: 2];
         got.item_count    = rsp_tdata[RSP_COUNT_LSB +: 5];
         got.head_valid    = rsp_tdata[RSP_HEAD_VALID_BIT];
         got.head_item     = rsp_tdata[RSP_HEAD_ITEM_LSB +: 4];
         got.head_key      = rsp_tdata[RSP_HEAD_KEY_LSB +: 32];
         got.cursor_at_end = rsp_tdata[RSP_CUR_END_BIT];
         got.cursor_item   = rsp_tdata[RSP_CUR_ITEM_LSB +: 4];
         if (pending_views.size() == 0) begin
            fail_count++;
            $display("%0t ns: response with none expected, expected nothing, actual %0h",
                     $time, rsp_tdata);
         end else begin
            want = pending_views.pop_front();
            check_field("status",        32'(want.status),        32'(got.status));
            check_field("item_count",    32'(want.item_count),    32'(got.item_count));
            check_field("head_valid",    32'(want.head_valid),    32'(got.head_valid));
            check_field("head_item",     32'(want.head_item),     32'(got.head_item));
            check_field("head_key",      want.head_key,           got.head_key);
            check_field("cursor_at_end", 32'(want.cursor_at_end), 32'(got.cursor_at_end));
            check_field("cursor_item",   32'(want.cursor_item),   32'(got.cursor_item));
            checked_count++;
            if (want.status != STAT_OK) flagged_count++;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles, %0d responses outstanding",
                  $time, QUIET_LIMIT, pending_views.size());
         $display("[ordered_item_list_engine_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      idle_on    = 1'b1;
      fail_count = 0;
      checked_count = 0;
      flagged_count = 0;
      quiet_cycles  = 0;
      max_fill      = 0;
      for (int i = 0; i < 4; i++) cmd_seen[i] = 0;
      clear_list();

      // Reset is held at the start, once, and then released.
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_drain(1'b1);
      test_random(400);
      // Long stretch with both channels running flat out.
      idle_on = 1'b0;
      test_random(250);
      test_fill_and_drain(1'b0);
      idle_on = 1'b1;
      test_random(350);

      // Drop valid, wait for every response, then watch for strays.
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d sorted inserts, %0d cursor inserts, %0d removes, %0d no-ops",
               cmd_seen[CMD_SORTED], cmd_seen[CMD_CURSOR], cmd_seen[CMD_REMOVE],
               cmd_seen[CMD_NOP]);
      $display("Checked %0d responses, %0d flagged; list held up to %0d items",
               checked_count, flagged_count, max_fill);
      if (fail_count == 0) begin
         $display("[ordered_item_list_engine_unit] OK");
      end else begin
         $display("[ordered_item_list_engine_unit] ERROR");
      end
      $finish;
   end

endmodule
